/* rtl/core/cts_pkg.sv */
// Shared types and constants for the command token selector.
`default_nettype none

package cts_pkg;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_TOKEN_SELECT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT_ONLY   = 1'd1;

    localparam int RESULT_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       line_done;
        logic [7:0] tokens_seen;
        logic       token_found;
    } result_t;

    // Results caused by one byte: a character result comes before the summary.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } lex_out_t;

endpackage

`default_nettype wire

/* rtl/core/cts_if.sv */
// Valid/ready channel interfaces for command bytes and result items.
`default_nettype none

interface cts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       line_end;

    modport source (output valid, output char_in, output line_end, input ready);
    modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

interface cts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       line_done;
    logic [7:0] tokens_seen;
    logic       token_found;

    modport source (output valid, output out_char, output char_valid, output line_done,
                    output tokens_seen, output token_found, input ready);
    modport sink   (input valid, input out_char, input char_valid, input line_done,
                    input tokens_seen, input token_found, output ready);
endinterface

`default_nettype wire

/* rtl/core/command_token_selector_top.sv */
// Top level of the command token selector: input register, tokenizer, result queue.
//
//   channel  dir  payload                                                  transaction
//   cmd      in   char_in, line_end                                        valid && ready
//   tok      out  out_char, char_valid, line_done, tokens_seen, token_found valid && ready
//   cfg      in   cfg_index, cfg_data                                      cfg_we
//
// One byte is taken per cycle while the queue has room for two results. A byte waits in the
// input register while the tokenizer updates its state and writes zero, one or two results
// into the result queue, which delivers them on tok one at a time, so the sustained rate is
// set by the single-read result queue.
// Reset clears the tokenizer state, the registers and the queue; no clearing pass.
// When tok stalls, the queue fills; once fewer than two slots are free, cmd.ready drops while a byte waits.
`default_nettype none

module command_token_selector_top
    import cts_pkg::*;
#(
    parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    cts_in_if.sink                      cmd,
    cts_out_if.source                   tok,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       end_reg;
    logic       room;
    logic       step;
    lex_out_t   results;

    assign step      = in_valid_reg && room;
    assign cmd.ready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            char_reg <= cmd.char_in;
            end_reg  <= cmd.line_end;
        end
    end

    cts_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .char_in   (char_reg),
        .line_end  (end_reg),
        .results   (results)
    );

    cts_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (step),
        .results (results),
        .room    (room),
        .res     (tok)
    );

endmodule

`default_nettype wire

/* rtl/core/cts_lexer.sv */
// Tokenizer state, configuration registers and per-byte result logic.
`default_nettype none

module cts_lexer
    import cts_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   step,
    input  wire logic [7:0]             char_in,
    input  wire logic                   line_end,
    output lex_out_t                    results
);

    typedef enum logic [1:0] {
        MODE_BETWEEN,
        MODE_WORD,
        MODE_QUOTED
    } mode_t;

    logic [7:0] token_select_reg;
    logic       count_only_reg;

    mode_t      mode_reg,      mode_next;
    logic       esc_act_reg,   esc_act_next;
    logic       esc_dig_reg,   esc_dig_next;
    logic [7:0] esc_code_reg,  esc_code_next;
    logic [7:0] count_reg,     count_next;
    logic       halted_reg,    halted_next;

    logic       is_quote;
    logic       is_space;
    logic       is_bslash;
    logic       is_digit;
    logic       in_token;
    logic       take;
    logic       emit;
    logic       selected;
    logic [7:0] value;
    logic       char_out;
    result_t    char_res;
    result_t    sum_res;

    assign is_quote  = (char_in == CH_DQUOTE) || (char_in == CH_SQUOTE);
    assign is_space  = (char_in == CH_SPACE);
    assign is_bslash = (char_in == CH_BSLASH);
    assign is_digit  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);

    always_comb
    begin
        mode_next     = mode_reg;
        esc_act_next  = esc_act_reg;
        esc_dig_next  = esc_dig_reg;
        esc_code_next = esc_code_reg;
        count_next    = count_reg;
        halted_next   = halted_reg;
        in_token      = 1'b0;
        take          = 1'b0;
        emit          = 1'b0;
        value         = char_in;

        if (!halted_reg)
        begin
            in_token = 1'b1;
            case (mode_reg)
                MODE_WORD, MODE_QUOTED:
                begin
                    in_token = 1'b1;
                end
                default:
                begin
                    mode_next = MODE_BETWEEN;
                    if (is_quote)
                    begin
                        mode_next = MODE_QUOTED;
                        in_token  = 1'b0;
                        if (count_reg != 8'hFF)
                        begin
                            count_next = count_reg + 8'd1;
                        end
                    end
                    else if (!is_space)
                    begin
                        mode_next = MODE_WORD;
                        if (count_reg != 8'hFF)
                        begin
                            count_next = count_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        in_token = 1'b0;
                    end
                end
            endcase
        end

        // Token index compare is one bit wider so a select of 255 never matches.
        selected = ({1'b0, count_next} == ({1'b0, token_select_reg} + 9'd1));

        if (in_token)
        begin
            take = 1'b1;
            if (!esc_act_reg)
            begin
                if (is_bslash)
                begin
                    esc_act_next  = 1'b1;
                    esc_dig_next  = 1'b0;
                    esc_code_next = 8'd0;
                    take          = 1'b0;
                end
                else if ((mode_next == MODE_QUOTED && is_quote) ||
                         (mode_next == MODE_WORD && is_space))
                begin
                    mode_next = MODE_BETWEEN;
                    take      = 1'b0;
                    if (!count_only_reg && selected)
                    begin
                        halted_next = 1'b1;
                    end
                end
            end
            else if (!is_digit)
            begin
                esc_act_next = 1'b0;
            end

            if (take)
            begin
                if (esc_act_next)
                begin
                    // Accumulate a decimal digit, modulo 256.
                    esc_dig_next  = 1'b1;
                    esc_code_next = (esc_code_reg << 3) + (esc_code_reg << 1)
                                    + (char_in - CH_ZERO);
                end
                else if (esc_dig_reg)
                begin
                    // Drop the terminator and emit the code.
                    value         = esc_code_reg;
                    esc_dig_next  = 1'b0;
                    esc_code_next = 8'd0;
                    emit          = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
        end

        char_out = emit && !count_only_reg && selected;

        char_res.out_char    = value;
        char_res.char_valid  = 1'b1;
        char_res.line_done   = 1'b0;
        char_res.tokens_seen = 8'd0;
        char_res.token_found = 1'b0;

        sum_res.out_char    = 8'd0;
        sum_res.char_valid  = 1'b0;
        sum_res.line_done   = 1'b1;
        sum_res.tokens_seen = count_next;
        sum_res.token_found = (count_next > token_select_reg);

        results.count  = {1'b0, char_out} + {1'b0, line_end};
        results.first  = char_out ? char_res : sum_res;
        results.second = sum_res;

        if (line_end)
        begin
            mode_next     = MODE_BETWEEN;
            esc_act_next  = 1'b0;
            esc_dig_next  = 1'b0;
            esc_code_next = 8'd0;
            count_next    = 8'd0;
            halted_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_select_reg <= 8'd0;
            count_only_reg   <= 1'b0;
            mode_reg         <= MODE_BETWEEN;
            esc_act_reg      <= 1'b0;
            esc_dig_reg      <= 1'b0;
            esc_code_reg     <= 8'd0;
            count_reg        <= 8'd0;
            halted_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TOKEN_SELECT: token_select_reg <= cfg_data[7:0];
                    REG_COUNT_ONLY:   count_only_reg   <= cfg_data[0];
                    default:          ;
                endcase
            end
            if (step)
            begin
                mode_reg     <= mode_next;
                esc_act_reg  <= esc_act_next;
                esc_dig_reg  <= esc_dig_next;
                esc_code_reg <= esc_code_next;
                count_reg    <= count_next;
                halted_reg   <= halted_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cts_result_fifo.sv */
// Small result queue: takes up to two results a cycle, delivers one a cycle while res.ready is high.
`default_nettype none

module cts_result_fifo
    import cts_pkg::*;
#(
    parameter int DEPTH = RESULT_DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire lex_out_t results,
    output logic          room,
    cts_out_if.source     res
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t             mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]    wr_ptr_inc;
    logic [CNT_W-1:0]    fill_reg,   fill_next;
    logic [1:0]          n_wr;
    logic                pop;
    result_t             head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // Hold off new bytes unless a two-result transaction fits.
    assign room = (fill_reg <= CNT_W'(DEPTH - 2));
    assign n_wr = push ? results.count : 2'd0;
    assign pop  = res.valid && res.ready;
    assign head = mem[rd_ptr_reg];

    assign res.valid       = (fill_reg != '0);
    assign res.out_char    = head.out_char;
    assign res.char_valid  = head.char_valid;
    assign res.line_done   = head.line_done;
    assign res.tokens_seen = head.tokens_seen;
    assign res.token_found = head.token_found;

    always_comb
    begin
        wr_ptr_inc  = ptr_inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        case (n_wr)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg + CNT_W'(n_wr) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_wr != 2'd0)
        begin
            mem[wr_ptr_reg] <= results.first;
        end
        if (n_wr == 2'd2)
        begin
            mem[wr_ptr_inc] <= results.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

/* sim/command_token_selector_top_test.sv */
`timescale 1ns / 1ps
// Testbench for the command token selector: directed and random command lines checked per result.

module command_token_selector_top_test
    import cts_pkg::*;
;

    typedef enum logic [1:0] {LEX_BETWEEN, LEX_WORD, LEX_QUOTED} lex_mode_t;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cts_in_if  cmd_ch();
    cts_out_if tok_ch();

    command_token_selector_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .tok       (tok_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Tokenizer state mirrored by the predictor
    logic [7:0] sel_reg    = 8'd0;
    logic       count_mode = 1'b0;
    lex_mode_t  lex_q      = LEX_BETWEEN;
    logic       esc_active = 1'b0;
    logic       esc_digits = 1'b0;
    logic [7:0] esc_code   = 8'd0;
    logic [7:0] tok_count  = 8'd0;
    logic       halted_q   = 1'b0;

    result_t    due_results[$];
    logic [7:0] line_buf[$];
    result_t    seen_result;
    result_t    want_result;
    int         mismatches  = 0;
    int         cycle_count = 0;
    bit         send_gaps   = 1'b0;
    bit         recv_stalls = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void append_byte(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    function automatic void queue_result(input result_t r);
        due_results.insert(due_results.size(), r);
    endfunction

    function automatic logic token_selected();
        return {1'b0, tok_count} == {1'b0, sel_reg} + 9'd1;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf("char %h valid %b done %b count %0d found %b",
                         r.out_char, r.char_valid, r.line_done, r.tokens_seen, r.token_found);
    endfunction

    // Work out the results one accepted byte causes and queue them
    function automatic void tokenize_byte(input logic [7:0] ch, input logic last);
        logic       inside_tok;
        logic       opened;
        logic       keep;
        logic       emit;
        logic [7:0] val;
        if (!halted_q)
        begin
            inside_tok = 1'b1;
            opened     = 1'b0;
            if (lex_q == LEX_BETWEEN)
            begin
                if (ch == CH_DQUOTE || ch == CH_SQUOTE)
                begin
                    lex_q      = LEX_QUOTED;
                    opened     = 1'b1;
                    inside_tok = 1'b0;
                end
                else if (ch != CH_SPACE)
                begin
                    lex_q  = LEX_WORD;
                    opened = 1'b1;
                end
                else
                    inside_tok = 1'b0;
            end
            // saturate the count at 255
            if (opened && tok_count != 8'hFF)
                tok_count = tok_count + 8'd1;
            if (inside_tok)
            begin
                keep = 1'b1;
                if (!esc_active)
                begin
                    if (ch == CH_BSLASH)
                    begin
                        esc_active = 1'b1;
                        esc_digits = 1'b0;
                        esc_code   = 8'd0;
                        keep       = 1'b0;
                    end
                    else if ((lex_q == LEX_QUOTED && (ch == CH_DQUOTE || ch == CH_SQUOTE)) ||
                             (lex_q == LEX_WORD && ch == CH_SPACE))
                    begin
                        lex_q = LEX_BETWEEN;
                        keep  = 1'b0;
                        if (!count_mode && token_selected())
                            halted_q = 1'b1;
                    end
                end
                else if (ch < CH_ZERO || ch > CH_NINE)
                    esc_active = 1'b0;
                if (keep)
                begin
                    emit = 1'b1;
                    val  = ch;
                    if (esc_active)
                    begin
                        esc_digits = 1'b1;
                        esc_code   = esc_code * 8'd10 + (ch - CH_ZERO);
                        emit       = 1'b0;
                    end
                    else if (esc_digits)
                    begin
                        val        = esc_code;
                        esc_digits = 1'b0;
                        esc_code   = 8'd0;
                    end
                    if (emit && !count_mode && token_selected())
                        queue_result(result_t'{val, 1'b1, 1'b0, 8'd0, 1'b0});
                end
            end
        end
        if (last)
        begin
            queue_result(result_t'{8'd0, 1'b0, 1'b1, tok_count, tok_count > sel_reg});
            lex_q      = LEX_BETWEEN;
            esc_active = 1'b0;
            esc_digits = 1'b0;
            esc_code   = 8'd0;
            tok_count  = 8'd0;
            halted_q   = 1'b0;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && tok_ch.valid === 1'b1 && tok_ch.ready === 1'b1)
        begin
            seen_result = result_t'{tok_ch.out_char, tok_ch.char_valid, tok_ch.line_done,
                                    tok_ch.tokens_seen, tok_ch.token_found};
            if (due_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %s",
                         $time, fmt_result(seen_result));
            end
            else
            begin
                want_result = due_results.pop_front();
                if (seen_result !== want_result)
                begin
                    mismatches++;
                    $display("%0t: result mismatch, expected %s, actual %s", $time,
                             fmt_result(want_result), fmt_result(seen_result));
                end
            end
        end
    end

    // Result side: stall in random bursts while enabled
    initial
    begin
        tok_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (recv_stalls && $urandom_range(0, 5) == 0)
            begin
                tok_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            tok_ch.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] ch, input logic last);
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.char_in  <= ch;
        cmd_ch.line_end <= last;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        tokenize_byte(ch, last);
    endtask

    task automatic send_buffer(input logic ends_line);
        foreach (line_buf[i])
            send_byte(line_buf[i], ends_line && i == line_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Drop valid, wait for every queued result, then let in-flight bytes settle
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input logic [7:0] sel, input logic co);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TOKEN_SELECT;
        cfg_data  <= sel;
        @(posedge clk);
        cfg_index <= REG_COUNT_ONLY;
        cfg_data  <= CFG_DATA_W'(co);
        @(posedge clk);
        cfg_we     <= 1'b0;
        sel_reg    = sel;
        count_mode = co;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic void add_body_char();
        int         pick;
        logic [7:0] term;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            append_byte(plain_char());
        else if (pick < 9)
        begin
            append_byte(CH_BSLASH);
            if ($urandom_range(0, 1) == 1)
            begin
                repeat ($urandom_range(1, 3))
                    append_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
                do
                    term = 8'($urandom_range(0, 255));
                while (term >= CH_ZERO && term <= CH_NINE);
                append_byte(term);
            end
            else
                append_byte(8'($urandom_range(0, 255)));
        end
        else
            append_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_line();
        int kind;
        line_buf.delete();
        repeat ($urandom_range(0, 6))
        begin
            repeat ($urandom_range(0, 2)) append_byte(CH_SPACE);
            kind = $urandom_range(0, 9);
            if (kind < 6)
                repeat ($urandom_range(1, 5)) add_body_char();
            else if (kind < 9)
            begin
                append_byte($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
                repeat ($urandom_range(0, 5)) add_body_char();
                if ($urandom_range(0, 7) != 0)
                    append_byte($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
            end
            else
                repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(0, 255)));
        end
        // end some lines with escape digits still pending
        kind = $urandom_range(0, 5);
        if (kind == 0)
        begin
            append_byte(CH_BSLASH);
            append_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        else if (kind == 1 || line_buf.size() == 0)
            append_byte(8'($urandom_range(0, 255)));
    endfunction

    task automatic test_directed_lines();
        // quoted text closed by the other quote, escaped quote, halt after the token
        set_regs(8'd1, 1'b0);
        send_text("a \"b\\\"c' d");
        // decimal escape, byte extremes, escape digits pending at line end
        drain_results();
        set_regs(8'd0, 1'b0);
        line_buf = '{CH_BSLASH, "6", "5", ";", 8'hFF, 8'h00, CH_BSLASH, "1"};
        send_buffer(1'b1);
        // select 255 matches nothing
        drain_results();
        set_regs(8'hFF, 1'b0);
        send_text("a b");
        // escape tracked in count mode keeps the quote open
        drain_results();
        set_regs(8'd0, 1'b1);
        send_text("'\\3'x");
    endtask

    task automatic test_counter_saturation();
        drain_results();
        set_regs(8'd254, 1'b1);
        line_buf.delete();
        repeat (257)
        begin
            append_byte(plain_char());
            append_byte(CH_SPACE);
        end
        send_buffer(1'b0);
        // switch to emitting mid-line: the saturated count now matches token 254
        drain_results();
        set_regs(8'd254, 1'b0);
        line_buf = '{plain_char(), plain_char(), CH_SPACE, plain_char(), plain_char()};
        send_buffer(1'b1);
    endtask

    task automatic test_random_lines(input int byte_budget);
        int         sent;
        int         pick;
        logic [7:0] sel;
        sent = 0;
        while (sent < byte_budget)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    sel = 8'($urandom_range(0, 3));
                else if (pick == 6)
                    sel = 8'd254;
                else if (pick == 7)
                    sel = 8'hFF;
                else
                    sel = 8'($urandom_range(0, 255));
                drain_results();
                set_regs(sel, $urandom_range(0, 3) == 0);
            end
            build_line();
            send_buffer(1'b1);
            sent += line_buf.size();
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.char_in  <= 8'd0;
        cmd_ch.line_end <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        test_directed_lines();
        test_counter_saturation();
        test_random_lines(450);

        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        test_random_lines(150);

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* command_token_selector_top.f */
rtl/core/cts_pkg.sv
rtl/core/cts_if.sv
rtl/core/cts_lexer.sv
rtl/core/cts_result_fifo.sv
rtl/core/command_token_selector_top.sv
sim/command_token_selector_top_test.sv
